// ===== src/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrr_pkg
// Types and constants shared by the 1bpp line/rectangle raster core.
// ----------------------------------------------------------------------------
`default_nettype none

package lrr_pkg;

  // command codes on the input channel
  localparam logic [1:0] ACT_LINE = 2'd0;
  localparam logic [1:0] ACT_RECT = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INVERSE = 2'd0;
  localparam logic [1:0] REG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_HEIGHT  = 2'd2;

  localparam logic [7:0] RST_WIDTH  = 8'd128;
  localparam logic [6:0] RST_HEIGHT = 7'd64;

  localparam logic [7:0] MSB_MASK = 8'h80;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    K_NOP,
    K_LINE,
    K_RECT,
    K_READ
  } lrr_kind_t;

  typedef struct packed {
    logic       inverse;
    logic [7:0] width;
    logic [6:0] height;
  } lrr_cfg_t;

  typedef struct packed {
    lrr_kind_t          kind;
    logic [7:0]         xa;
    logic [7:0]         ya;
    logic [7:0]         xb;
    logic [7:0]         yb;
    logic               color;
    logic [9:0]         addr;
    logic [7:0]         dx;
    logic [7:0]         dy;
    logic               sx;
    logic               sy;
    logic signed [9:0]  err;
  } lrr_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX,
    S_WR,
    S_RDWAIT,
    S_DONE
  } lrr_state_t;

endpackage

`default_nettype wire

// ===== src/lrr_front.sv =====
// ----------------------------------------------------------------------------
// lrr_front
// Accepts commands, masks coordinates, classifies them and sets up the
// Bresenham terms before they enter the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lrr_front import lrr_pkg::*; #(
  parameter int COORD_BITS = 8
) (
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_start_x,
  input  wire logic [7:0] in_start_y,
  input  wire logic [7:0] in_end_x,
  input  wire logic [7:0] in_end_y,
  input  wire logic       in_pixel_color,
  input  wire logic [9:0] in_read_address,
  input  wire logic       q_full,
  input  wire logic       clearing,
  output logic            push,
  output lrr_cmd_t        cmd
);

  localparam logic [7:0] CMASK = 8'((1 << COORD_BITS) - 1);

  logic [7:0] xa, ya, xb, yb;
  logic [7:0] dx, dy;

  assign xa = in_start_x & CMASK;
  assign ya = in_start_y & CMASK;
  assign xb = in_end_x & CMASK;
  assign yb = in_end_y & CMASK;

  assign dx = (xb > xa) ? (xb - xa) : (xa - xb);
  assign dy = (yb > ya) ? (yb - ya) : (ya - yb);

  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    cmd.xa    = xa;
    cmd.ya    = ya;
    cmd.xb    = xb;
    cmd.yb    = yb;
    cmd.color = in_pixel_color;
    cmd.addr  = in_read_address;
    cmd.dx    = dx;
    cmd.dy    = dy;
    cmd.sx    = (xa < xb);
    cmd.sy    = (ya < yb);
    cmd.err   = (dx > dy) ? $signed({3'b000, dx[7:1]}) : -$signed({3'b000, dy[7:1]});
    unique case (in_action)
      ACT_LINE: cmd.kind = K_LINE;
      ACT_RECT: cmd.kind = ((xb < xa) || (yb < ya)) ? K_NOP : K_RECT;
      ACT_READ: cmd.kind = K_READ;
      default:  cmd.kind = K_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/lrr_queue.sv =====
// ----------------------------------------------------------------------------
// lrr_queue
// Short command queue decoupling the front end from the draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lrr_queue import lrr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  lrr_cmd_t      push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          q_valid,
  output lrr_cmd_t      q_cmd
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  lrr_cmd_t        entry_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

// ===== src/lrr_back.sv =====
// ----------------------------------------------------------------------------
// lrr_back
// Draw engine: owns the frame store, walks line and rectangle pixels with
// read-modify-write byte updates, serves reads and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrr_back import lrr_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  lrr_cfg_t        cfg,
  input  wire logic       q_valid,
  input  lrr_cmd_t        q_cmd,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_was_read
);

  localparam int DEPTH = (MAX_WIDTH / 8) * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem [DEPTH];

  lrr_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  lrr_cmd_t      cmd_r;
  logic [7:0]    x_r, y_r;
  logic signed [9:0] err_r;
  logic [AW-1:0] pix_addr_r;
  logic [7:0]    pix_mask_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    res_data_r;
  logic          res_read_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_read_r;

  // geometry
  logic [8:0]  aw9, wmax, effw, ah9, effh;
  logic [5:0]  stride;
  logic [13:0] prod;
  logic [14:0] addr_full;
  logic        pix_in, last, advance, out_free, rd_ok;
  logic        pix_bit;

  assign aw9    = {1'b0, cfg.width};
  assign wmax   = (aw9 > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : aw9;
  assign effw   = {wmax[8:3], 3'b000};
  assign stride = wmax[8:3];
  assign ah9    = {2'b00, cfg.height};
  assign effh   = (ah9 > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : ah9;

  assign prod      = {6'b0, y_r} * {8'b0, stride};
  assign addr_full = {1'b0, prod} + {10'b0, x_r[7:3]};
  assign pix_in    = ({1'b0, x_r} < effw) && ({1'b0, y_r} < effh) &&
                     (addr_full < 15'(DEPTH));
  assign last      = (x_r == cmd_r.xb) && (y_r == cmd_r.yb);
  assign advance   = ((state_r == S_PIX) && !pix_in) || (state_r == S_WR);
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_ok     = ({5'b0, cmd_r.addr} < 15'(DEPTH));
  assign pix_bit   = cmd_r.color ^ cfg.inverse;

  // next pixel position
  logic signed [10:0] dxs, dys, err_w;
  logic               c1, c2;
  logic [7:0]         x_nxt, y_nxt;
  logic signed [9:0]  err_nxt;

  assign dxs = $signed({3'b000, cmd_r.dx});
  assign dys = $signed({3'b000, cmd_r.dy});
  assign c1  = $signed({err_r[9], err_r}) > -dxs;
  assign c2  = $signed({err_r[9], err_r}) < dys;
  assign err_w = $signed({err_r[9], err_r}) - (c1 ? dys : 11'sd0) + (c2 ? dxs : 11'sd0);

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    err_nxt = err_r;
    if (cmd_r.kind == K_RECT) begin
      if (x_r == cmd_r.xb) begin
        x_nxt = cmd_r.xa;
        y_nxt = y_r + 8'd1;
      end else begin
        x_nxt = x_r + 8'd1;
      end
    end else begin
      err_nxt = err_w[9:0];
      if (c1) x_nxt = cmd_r.sx ? x_r + 8'd1 : x_r - 8'd1;
      if (c2) y_nxt = cmd_r.sy ? y_r + 8'd1 : y_r - 8'd1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            K_LINE, K_RECT: state_nxt = S_PIX;
            K_READ:         state_nxt = S_RDWAIT;
            K_NOP:          state_nxt = S_DONE;
          endcase
        end
      end
      S_PIX: begin
        if (pix_in) state_nxt = S_WR;
        else if (last) state_nxt = S_DONE;
      end
      S_WR: begin
        state_nxt = last ? S_DONE : S_PIX;
      end
      S_RDWAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;
  logic          ld_out;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr_r;
    mem_wdata = pix_bit ? (rd_data_r | pix_mask_r) : (rd_data_r & ~pix_mask_r);
    mem_raddr = AW'(addr_full);
    q_pop     = 1'b0;
    ld_out    = 1'b0;
    clearing  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_IDLE: begin
        q_pop     = q_valid;
        mem_raddr = AW'({5'b0, q_cmd.addr});
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      S_DONE: begin
        ld_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ld_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r      <= q_cmd;
      x_r        <= q_cmd.xa;
      y_r        <= q_cmd.ya;
      err_r      <= q_cmd.err;
      res_data_r <= '0;
      res_read_r <= 1'b0;
    end
    if (advance) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
    if (state_r == S_PIX) begin
      pix_addr_r <= AW'(addr_full);
      pix_mask_r <= MSB_MASK >> x_r[2:0];
    end
    if (state_r == S_RDWAIT) begin
      res_data_r <= rd_ok ? rd_data_r : 8'd0;
      res_read_r <= 1'b1;
    end
    if (ld_out) begin
      out_data_r <= res_data_r;
      out_read_r <= res_read_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_was_read  = out_read_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && q_valid)
    else $error("command popped outside idle");

  a_wr_after_pix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ($past(state_r) == S_PIX))
    else $error("pixel write without preceding read");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result dropped while output register busy");

endmodule

`default_nettype wire

// ===== src/line_rect_raster_1bpp_core.sv =====
// ----------------------------------------------------------------------------
// line_rect_raster_1bpp_core
// 1bpp frame store with Bresenham line, rectangle fill and byte read commands.
//
// Input channel (in_valid/in_stall) takes one command per transaction:
// line, rectangle or read. Each command gives exactly one result on the
// output channel (out_valid/out_stall): the byte for a read, zero otherwise.
// Config writes (cfg_valid/cfg_ready, cfg_ready always high) set inverse
// mode, active width and active height; write them only while idle.
// A front end classifies commands into a two-deep queue, so new commands
// are taken while the engine draws or a result waits on a stalled receiver.
// Throughput is set by the single-port read-modify-write of the frame store:
// a drawn pixel is read in S_PIX and written in S_WR, a clipped pixel only
// passes S_PIX; each command adds S_IDLE and S_DONE, a read also S_RDWAIT, and
// out_valid rises after S_DONE finds the output register free.
// Reset clears the store with one byte per cycle, (MAX_WIDTH/8)*MAX_HEIGHT
// bytes (1024 by default); in_stall stays high until that pass finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rect_raster_1bpp_core import lrr_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64,
  parameter int COORD_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_start_x,
  input  wire logic [7:0] in_start_y,
  input  wire logic [7:0] in_end_x,
  input  wire logic [7:0] in_end_y,
  input  wire logic       in_pixel_color,
  input  wire logic [9:0] in_read_address,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_was_read,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  lrr_cfg_t cfg_r;
  lrr_cmd_t push_cmd, q_cmd;
  logic     push, q_full, q_valid, q_pop, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inverse <= 1'b0;
      cfg_r.width   <= RST_WIDTH;
      cfg_r.height  <= RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INVERSE: cfg_r.inverse <= cfg_data[0];
        REG_WIDTH:   cfg_r.width   <= cfg_data;
        REG_HEIGHT:  cfg_r.height  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  lrr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_pixel_color (in_pixel_color),
    .in_read_address(in_read_address),
    .q_full         (q_full),
    .clearing       (clearing),
    .push           (push),
    .cmd            (push_cmd)
  );

  lrr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  lrr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data),
    .out_was_read (out_was_read)
  );

endmodule

`default_nettype wire
